/* sv/sts_pkg.sv */
package sts_pkg;

  localparam int BracketDepth = 64;
  localparam int StackAw      = (BracketDepth > 1) ? $clog2(BracketDepth) : 1;
  localparam int StackCw      = $clog2(BracketDepth + 1);
  localparam int LineWidth    = 20;
  localparam int ColumnWidth  = 16;

  localparam logic [4:0] ModeIdle  = 5'd0;
  localparam logic [4:0] ModeInt   = 5'd1;
  localparam logic [4:0] ModeFrac  = 5'd2;
  localparam logic [4:0] ModeId1   = 5'd3;
  localparam logic [4:0] ModeId2   = 5'd4;
  localparam logic [4:0] ModeOp    = 5'd5;
  localparam logic [4:0] ModeStr   = 5'd6;
  localparam logic [4:0] ModeHash  = 5'd7;
  localparam logic [4:0] ModeLinec = 5'd8;
  localparam logic [4:0] ModeBlock = 5'd9;

  localparam logic [5:0] KindInt   = 6'd0;
  localparam logic [5:0] KindFloat = 6'd1;
  localparam logic [5:0] KindIdent = 6'd2;
  localparam logic [5:0] KindDq    = 6'd3;
  localparam logic [5:0] KindSq    = 6'd4;
  localparam logic [5:0] KindSlash = 6'd14;
  localparam logic [5:0] KindOpen  = 6'd31;
  localparam logic [5:0] KindClose = 6'd32;
  localparam logic [5:0] KindOther = 6'd33;

  localparam logic [2:0] ErrNone    = 3'd0;
  localparam logic [2:0] ErrNumber  = 3'd1;
  localparam logic [2:0] ErrBracket = 3'd2;
  localparam logic [2:0] ErrString  = 3'd3;
  localparam logic [2:0] ErrComment = 3'd4;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  first;
    logic [19:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic [6:0]  level;
    logic [2:0]  err;
    logic        endr;
    logic        last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_id_start(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f) || (c == 8'h24);
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] c);
    case (c)
      8'h2b: return 6'd5;
      8'h2d: return 6'd8;
      8'h2a: return 6'd12;
      8'h2f: return 6'd14;
      8'h3d: return 6'd16;
      8'h21: return 6'd19;
      8'h3e: return 6'd21;
      8'h3c: return 6'd24;
      8'h2e: return 6'd27;
      8'h3a: return 6'd29;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] op_pair(input logic [7:0] f, input logic [7:0] c);
    case (f)
      8'h2b: return (c == 8'h2b) ? 6'd6 : (c == 8'h3d) ? 6'd7 : 6'd0;
      8'h2d: return (c == 8'h2d) ? 6'd9 : (c == 8'h3d) ? 6'd10 :
                    (c == 8'h3e) ? 6'd11 : 6'd0;
      8'h2a: return (c == 8'h3d) ? 6'd13 : 6'd0;
      8'h2f: return (c == 8'h3d) ? 6'd15 : 6'd0;
      8'h3d: return (c == 8'h3d) ? 6'd17 : (c == 8'h3e) ? 6'd18 : 6'd0;
      8'h21: return (c == 8'h3d) ? 6'd20 : 6'd0;
      8'h3e: return (c == 8'h3d) ? 6'd22 : (c == 8'h3e) ? 6'd23 : 6'd0;
      8'h3c: return (c == 8'h3d) ? 6'd25 : (c == 8'h3c) ? 6'd26 : 6'd0;
      8'h2e: return (c == 8'h2e) ? 6'd28 : 6'd0;
      8'h3a: return (c == 8'h3a) ? 6'd30 : 6'd0;
      default: return 6'd0;
    endcase
  endfunction

endpackage

/* sv/sts_out_queue.sv */
module sts_out_queue
  import sts_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  logic   [1:0] cnt_i,
  input  token_t tok_i [3],
  output logic   room_o,
  output logic   valid_o,
  output token_t tok_o,
  input  logic   pop_i
);

  token_t     mem_q [8];
  logic [2:0] wp_q, rp_q;
  logic [3:0] cnt_q;
  logic [3:0] cnt_d;

  assign valid_o = (cnt_q != 4'd0);
  assign tok_o   = mem_q[rp_q];
  assign room_o  = (cnt_q <= 4'd5);
  assign cnt_d   = cnt_q + (push_i ? {2'b00, cnt_i} : 4'd0) - {3'b000, pop_i};

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt_i) mem_q[wp_q + 3'(i)] <= tok_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + {1'b0, cnt_i};
      if (pop_i) rp_q <= rp_q + 3'd1;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/sts_scan.sv */
module sts_scan
  import sts_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  logic   [7:0] c_i,
  input  logic   eot_i,
  output logic   push_o,
  output logic   [1:0] cnt_o,
  output token_t tok_o [3]
);

  localparam logic [LineWidth-1:0]   LineMax = '1;
  localparam logic [ColumnWidth-1:0] ColMax  = '1;

  logic [4:0]  mode_q, mode_d;
  logic [5:0]  kind_q, kind_d;
  logic [19:0] sline_q, sline_d;
  logic [15:0] scol_q, scol_d;
  logic [15:0] len_q, len_d;
  logic [19:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  first_q, first_d;
  logic [1:0]  stack_q [BracketDepth];
  logic [StackCw-1:0] sp_q, sp_d;
  logic        halt_q, halt_d;
  logic        push_d;
  logic        wr_en;
  logic        pop_en;
  logic [1:0]  wr_code;
  token_t      tok_d [3];
  logic [1:0]  n;
  logic [1:0]  top;
  logic [6:0]  lvl;

  assign top = (sp_q != '0) ? stack_q[0] : 2'd0;
  assign lvl = (sp_q > StackCw'(127)) ? 7'd127 : 7'(sp_q);

  always_comb begin
    logic [LineWidth-1:0]   li;
    logic [ColumnWidth-1:0] co;
    logic [15:0]            le;
    logic                   go_idle;
    logic [1:0]             b;
    logic                   is_b;
    logic [5:0]             k;
    token_t                 t;
    mode_d  = mode_q;  kind_d = kind_q; sline_d = sline_q; scol_d = scol_q;
    len_d   = len_q;   line_d = line_q; col_d   = col_q;   prev_d = prev_q;
    first_d = first_q; sp_d   = sp_q;   halt_d  = halt_q;
    wr_en = 1'b0; pop_en = 1'b0; wr_code = 2'd0; n = 2'd0; go_idle = 1'b0;
    b = 2'd0; is_b = 1'b0; k = 6'd0; li = '0; co = '0; le = '0; t = '0;
    for (int i = 0; i < 3; i++) tok_d[i] = '0;

    if (step_i && !halt_q) begin
      if (eot_i) begin
        if (mode_q == ModeInt || mode_q == ModeFrac || mode_q == ModeId1 ||
            mode_q == ModeId2 || mode_q == ModeOp || mode_q == ModeStr ||
            mode_q == ModeBlock) begin
          t = '0;
          t.kind = (mode_q == ModeBlock) ? KindSlash : kind_q;
          t.first = (mode_q == ModeBlock) ? 8'h2f : first_q;
          t.line = sline_q; t.col = scol_q; t.len = len_q; t.level = lvl;
          t.err = (mode_q == ModeStr) ? ErrString :
                  (mode_q == ModeBlock) ? ErrComment : ErrNone;
          tok_d[n] = t; n = n + 2'd1;
        end
        if (sp_q != '0) begin
          t = '0;
          t.kind = KindOpen;
          t.first = (top == 2'd1) ? 8'h5b : (top == 2'd2) ? 8'h7b : 8'h28;
          t.line = line_q; t.col = col_q; t.level = lvl; t.err = ErrBracket;
          tok_d[n] = t; n = n + 2'd1;
        end
        t = '0;
        t.line = line_q; t.col = col_q; t.level = lvl; t.endr = 1'b1;
        tok_d[n] = t; n = n + 2'd1;
        mode_d = ModeIdle; kind_d = '0; sline_d = '0; scol_d = '0; len_d = '0;
        line_d = '0; col_d = '0; prev_d = '0; first_d = '0; sp_d = '0;
      end else begin
        li = line_q; co = col_q; le = len_q;
        unique case (mode_q)
          ModeInt: begin
            if (is_digit(c_i)) begin
              le = len_q + {15'd0, len_q != 16'hffff};
            end else if (c_i == 8'h2e) begin
              le = len_q + {15'd0, len_q != 16'hffff}; kind_d = KindFloat;
              mode_d = ModeFrac;
            end else go_idle = 1'b1;
            if (!go_idle) co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
          end
          ModeFrac: begin
            if (is_digit(c_i)) begin
              le = len_q + {15'd0, len_q != 16'hffff};
              co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            end else if (c_i == 8'h2e) begin
              t = '0; t.kind = kind_q; t.first = first_q; t.line = sline_q;
              t.col = scol_q; t.len = len_q; t.level = lvl; t.err = ErrNumber;
              tok_d[0] = t; n = 2'd1; halt_d = 1'b1;
            end else go_idle = 1'b1;
          end
          ModeId1, ModeId2: begin
            if (is_id_start(c_i) || is_digit(c_i) && (mode_q == ModeId2)) begin
              le = len_q + {15'd0, len_q != 16'hffff};
              co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            end else if (is_digit(c_i)) begin
              le = len_q + {15'd0, len_q != 16'hffff};
              co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
              mode_d = ModeId2;
            end else go_idle = 1'b1;
          end
          ModeOp: begin
            k = op_pair(first_q, c_i);
            if (first_q == 8'h2f && (c_i == 8'h2a || c_i == 8'h2f)) begin
              le = len_q + {15'd0, len_q != 16'hffff};
              co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
              prev_d = c_i;
              mode_d = (c_i == 8'h2a) ? ModeBlock : ModeLinec;
            end else if (k != 6'd0) begin
              t = '0; t.kind = k; t.first = first_q; t.line = sline_q;
              t.col = scol_q; t.len = len_q + {15'd0, len_q != 16'hffff};
              t.level = lvl;
              tok_d[0] = t; n = 2'd1;
              le = t.len; kind_d = k;
              co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
              mode_d = ModeIdle;
            end else go_idle = 1'b1;
          end
          ModeStr: begin
            le = len_q + {15'd0, len_q != 16'hffff};
            if (c_i == 8'h0a) begin
              li = line_q + {{(LineWidth-1){1'b0}}, line_q != LineMax};
              co = {{(ColumnWidth-1){1'b0}}, 1'b1};
            end else co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            if (c_i == first_q) begin
              t = '0; t.kind = kind_q; t.first = first_q; t.line = sline_q;
              t.col = scol_q; t.len = le; t.level = lvl;
              tok_d[0] = t; n = 2'd1; mode_d = ModeIdle;
            end
          end
          ModeHash: begin
            if (c_i != 8'h0a) co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            else go_idle = 1'b1;
          end
          ModeLinec: begin
            le = len_q + {15'd0, len_q != 16'hffff};
            if (c_i == 8'h0a) begin
              li = line_q + {{(LineWidth-1){1'b0}}, line_q != LineMax};
              co = '0; mode_d = ModeIdle;
            end else co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
          end
          ModeBlock: begin
            le = len_q + {15'd0, len_q != 16'hffff};
            if (c_i == 8'h0a) begin
              li = line_q + {{(LineWidth-1){1'b0}}, line_q != LineMax};
              co = '0;
            end else co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            if (prev_q == 8'h2a && c_i == 8'h2f) mode_d = ModeIdle;
            else prev_d = c_i;
          end
          default: go_idle = 1'b1;
        endcase

        if (go_idle) begin
          if (mode_q != ModeIdle && mode_q != ModeHash) begin
            t = '0; t.kind = kind_q; t.first = first_q; t.line = sline_q;
            t.col = scol_q; t.len = len_q; t.level = lvl;
            tok_d[0] = t; n = 2'd1;
          end
          mode_d = ModeIdle;
          k = op_single(c_i);
          is_b = 1'b1;
          case (c_i)
            8'h28, 8'h29: b = 2'd0;
            8'h5b, 8'h5d: b = 2'd1;
            8'h7b, 8'h7d: b = 2'd2;
            default: is_b = 1'b0;
          endcase
          t = '0; t.first = c_i; t.line = line_q; t.col = col_q;
          t.len = 16'd1; t.level = lvl;
          if (c_i == 8'h20) begin
            co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
          end else if (c_i == 8'h0d || c_i == 8'h09) begin
            co = col_q;
          end else if (c_i == 8'h0a) begin
            li = line_q + {{(LineWidth-1){1'b0}}, line_q != LineMax};
            co = '0;
          end else if (is_digit(c_i) || is_id_start(c_i) || k != 6'd0 ||
                       c_i == 8'h22 || c_i == 8'h27) begin
            sline_d = line_q; scol_d = col_q; first_d = c_i; le = 16'd1;
            co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            if (is_digit(c_i)) begin
              kind_d = KindInt; mode_d = ModeInt;
            end else if (is_id_start(c_i)) begin
              kind_d = KindIdent; mode_d = ModeId1;
            end else if (k != 6'd0) begin
              kind_d = k; mode_d = ModeOp;
            end else begin
              kind_d = (c_i == 8'h22) ? KindDq : KindSq; mode_d = ModeStr;
            end
          end else if (c_i == 8'h23) begin
            co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            mode_d = ModeHash;
          end else if (is_b && (c_i == 8'h28 || c_i == 8'h5b || c_i == 8'h7b)) begin
            t.kind = KindOpen;
            if (sp_q >= StackCw'(BracketDepth)) begin
              t.err = ErrBracket; halt_d = 1'b1;
            end else begin
              wr_en = 1'b1; wr_code = b; sp_d = sp_q + 1'b1;
              co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            end
            tok_d[n] = t; n = n + 2'd1;
          end else if (is_b) begin
            t.kind = KindClose;
            if (sp_q == '0 || top != b) begin
              t.err = ErrBracket; halt_d = 1'b1;
            end else begin
              pop_en = 1'b1;
              sp_d = sp_q - 1'b1;
              t.level = (sp_d > StackCw'(127)) ? 7'd127 : 7'(sp_d);
              co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            end
            tok_d[n] = t; n = n + 2'd1;
          end else begin
            t.kind = KindOther;
            co = col_q + {{(ColumnWidth-1){1'b0}}, col_q != ColMax};
            tok_d[n] = t; n = n + 2'd1;
          end
        end
        line_d = li; col_d = co; len_d = le;
      end
      if (n != 2'd0) tok_d[n - 2'd1].last = 1'b1;
    end
    push_d = (n != 2'd0);
  end

  assign push_o = push_d;
  assign cnt_o  = n;
  assign tok_o  = tok_d;

  // keep the innermost bracket at stage 0: shift down on push, up on pop
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_q[0] <= wr_code;
      for (int i = 1; i < BracketDepth; i++) stack_q[i] <= stack_q[i-1];
    end else if (pop_en) begin
      for (int i = 0; i < BracketDepth - 1; i++) stack_q[i] <= stack_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle; kind_q <= '0; sline_q <= '0; scol_q <= '0;
      len_q  <= '0; line_q <= '0; col_q <= '0; prev_q <= '0;
      first_q <= '0; sp_q <= '0; halt_q <= 1'b0;
    end else begin
      mode_q <= mode_d; kind_q <= kind_d; sline_q <= sline_d; scol_q <= scol_d;
      len_q  <= len_d; line_q <= line_d; col_q <= col_d; prev_q <= prev_d;
      first_q <= first_d; sp_q <= sp_d; halt_q <= halt_d;
    end
  end

endmodule

/* sv/source_token_scanner_core.sv */
// Latency: a byte accepted at one edge puts its first token beat on the output right
// after that edge if the queue was empty; several results give one beat per ready cycle.
// Throughput: one byte per cycle while the result queue has room for three beats.
// Reset (rst_ni low, asynchronous) returns the scanner to idle at line and
// column zero and empties the result queue; the bracket stack needs no clear.
module source_token_scanner_core
  import sts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_byte
  input  logic        s_axis_tuser,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // token_kind, first_byte, start_line,
                                     // start_column, token_length,
                                     // bracket_level, error_code, zero fill
  output logic        m_axis_tuser,  // end_report
  output logic        m_axis_tlast   // last_of_run
);

  logic   step, push, room;
  logic   [1:0] cnt;
  token_t toks [3];
  token_t head;

  assign s_axis_tready = room;
  assign step = s_axis_tvalid && room;

  sts_scan u_scan (
    .clk_i, .rst_ni, .step_i(step), .c_i(s_axis_tdata), .eot_i(s_axis_tuser),
    .push_o(push), .cnt_o(cnt), .tok_o(toks)
  );

  sts_out_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cnt_i(cnt), .tok_i(toks), .room_o(room),
    .valid_o(m_axis_tvalid), .tok_o(head), .pop_i(m_axis_tvalid && m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, head.err, head.level, head.len, head.col,
                         head.line, head.first, head.kind};
  assign m_axis_tuser = head.endr;
  assign m_axis_tlast = head.last;

endmodule

/* tb/source_token_scanner_core_tb.sv */
`timescale 1ns / 100ps

module source_token_scanner_core_tb;
  import sts_pkg::*;

  typedef enum logic [5:0] {
    OpPlus = 6'd5, OpInc, OpAddEq, OpMinus, OpDec, OpSubEq, OpArrow, OpStar, OpMulEq,
    OpSlash, OpDivEq, OpAssign, OpEq, OpFatArrow, OpNot, OpNe, OpGt, OpGe, OpShr,
    OpLt, OpLe, OpShl, OpDot, OpRange, OpColon, OpScope
  } op_e;

  class token_board;
    token_t      pending_tokens[$];
    bit          failed;
    logic [4:0]  mode;
    logic [5:0]  kind;
    logic [19:0] line, tok_line;
    logic [15:0] col, tok_col, len;
    logic [7:0]  first, prev;
    logic [7:0]  opens[BracketDepth];
    int          depth;
    bit          halted;

    function new();
      failed = 0;
      clear();
    endfunction

    function void clear();
      mode = ModeIdle;
      kind = KindInt;
      line = '0;
      tok_line = '0;
      col = '0;
      tok_col = '0;
      len = '0;
      first = '0;
      prev = '0;
      depth = 0;
      halted = 0;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit word_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function logic [5:0] single_op(logic [7:0] c);
      case (c)
        "+": return OpPlus;
        "-": return OpMinus;
        "*": return OpStar;
        "/": return OpSlash;
        "=": return OpAssign;
        "!": return OpNot;
        ">": return OpGt;
        "<": return OpLt;
        ".": return OpDot;
        ":": return OpColon;
        default: return '0;
      endcase
    endfunction

    function logic [5:0] double_op(logic [7:0] f, logic [7:0] c);
      case (f)
        "+": return c == "+" ? OpInc : c == "=" ? OpAddEq : '0;
        "-": return c == "-" ? OpDec : c == "=" ? OpSubEq : c == ">" ? OpArrow : '0;
        "*": return c == "=" ? OpMulEq : '0;
        "/": return c == "=" ? OpDivEq : '0;
        "=": return c == "=" ? OpEq : c == ">" ? OpFatArrow : '0;
        "!": return c == "=" ? OpNe : '0;
        ">": return c == "=" ? OpGe : c == ">" ? OpShr : '0;
        "<": return c == "=" ? OpLe : c == "<" ? OpShl : '0;
        ".": return c == "." ? OpRange : '0;
        ":": return c == ":" ? OpScope : '0;
        default: return '0;
      endcase
    endfunction

    function void col_up();
      if (col != '1) col++;
    endfunction

    function void len_up();
      if (len != '1) len++;
    endfunction

    function void line_up();
      if (line != '1) line++;
    endfunction

    function void add(logic [5:0] k, logic [7:0] fb, logic [19:0] ln, logic [15:0] cl,
                      logic [15:0] n, logic [2:0] err, logic endr);
      token_t t;
      t.kind = k;
      t.first = fb;
      t.line = ln;
      t.col = cl;
      t.len = n;
      t.level = 7'(depth);
      t.err = err;
      t.endr = endr;
      t.last = 1'b0;
      pending_tokens.push_back(t);
    endfunction

    function void flush(logic [2:0] err);
      add(kind, first, tok_line, tok_col, len, err, 1'b0);
    endfunction

    function void begin_token(logic [7:0] c, logic [5:0] k, logic [4:0] m);
      tok_line = line;
      tok_col = col;
      first = c;
      kind = k;
      len = 16'd1;
      mode = m;
      col_up();
    endfunction

    function void between_tokens(logic [7:0] c);
      logic [5:0] k;
      logic [7:0] want;
      k = single_op(c);
      want = c == ")" ? "(" : c == "]" ? "[" : "{";
      mode = ModeIdle;
      if (c == " ") col_up();
      else if (c == "\r" || c == "\t") ;
      else if (c == "\n") begin
        line_up();
        col = '0;
      end else if (digit(c)) begin_token(c, KindInt, ModeInt);
      else if (word_char(c)) begin_token(c, KindIdent, ModeId1);
      else if (c == "#") begin
        col_up();
        mode = ModeHash;
      end else if (k != '0) begin_token(c, k, ModeOp);
      else if (c == "\"") begin_token(c, KindDq, ModeStr);
      else if (c == "'") begin_token(c, KindSq, ModeStr);
      else if (c == "(" || c == "[" || c == "{") begin
        if (depth >= BracketDepth) begin
          add(KindOpen, c, line, col, 16'd1, ErrBracket, 1'b0);
          halted = 1;
        end else begin
          add(KindOpen, c, line, col, 16'd1, ErrNone, 1'b0);
          opens[depth] = c;
          depth++;
          col_up();
        end
      end else if (c == ")" || c == "]" || c == "}") begin
        if (depth == 0 || opens[depth-1] != want) begin
          add(KindClose, c, line, col, 16'd1, ErrBracket, 1'b0);
          halted = 1;
        end else begin
          depth--;
          add(KindClose, c, line, col, 16'd1, ErrNone, 1'b0);
          col_up();
        end
      end else begin
        add(KindOther, c, line, col, 16'd1, ErrNone, 1'b0);
        col_up();
      end
    endfunction

    function void scan(logic [7:0] c);
      logic [5:0] k;
      case (mode)
        ModeInt: begin
          if (digit(c)) begin
            len_up();
            col_up();
            return;
          end
          if (c == ".") begin
            len_up();
            col_up();
            kind = KindFloat;
            mode = ModeFrac;
            return;
          end
          flush(ErrNone);
        end
        ModeFrac: begin
          if (digit(c)) begin
            len_up();
            col_up();
            return;
          end
          if (c == ".") begin
            flush(ErrNumber);
            halted = 1;
            return;
          end
          flush(ErrNone);
        end
        ModeId1: begin
          if (word_char(c) || digit(c)) begin
            len_up();
            col_up();
            if (digit(c)) mode = ModeId2;
            return;
          end
          flush(ErrNone);
        end
        ModeId2: begin
          if (word_char(c) || digit(c)) begin
            len_up();
            col_up();
            return;
          end
          flush(ErrNone);
        end
        ModeOp: begin
          if (first == "/" && (c == "*" || c == "/")) begin
            len_up();
            col_up();
            prev = c;
            mode = c == "*" ? ModeBlock : ModeLinec;
            return;
          end
          k = double_op(first, c);
          if (k != '0) begin
            len_up();
            col_up();
            kind = k;
            flush(ErrNone);
            mode = ModeIdle;
            return;
          end
          flush(ErrNone);
        end
        ModeStr: begin
          len_up();
          if (c == "\n") begin
            line_up();
            col = 16'd1;
          end else col_up();
          if (c == first) begin
            flush(ErrNone);
            mode = ModeIdle;
          end
          return;
        end
        ModeHash: begin
          if (c != "\n") begin
            col_up();
            return;
          end
        end
        ModeLinec: begin
          len_up();
          if (c == "\n") begin
            line_up();
            col = '0;
            mode = ModeIdle;
          end else col_up();
          return;
        end
        ModeBlock: begin
          len_up();
          if (c == "\n") begin
            line_up();
            col = '0;
          end else col_up();
          if (prev == "*" && c == "/") mode = ModeIdle;
          else prev = c;
          return;
        end
        default: ;
      endcase
      between_tokens(c);
    endfunction

    function void note(logic [7:0] c, bit eot);
      int n0;
      n0 = pending_tokens.size();
      if (halted) return;
      if (eot) begin
        case (mode)
          ModeInt, ModeFrac, ModeId1, ModeId2, ModeOp: flush(ErrNone);
          ModeStr: flush(ErrString);
          ModeBlock: add(KindSlash, "/", tok_line, tok_col, len, ErrComment, 1'b0);
          default: ;
        endcase
        if (depth > 0) add(KindOpen, opens[depth-1], line, col, '0, ErrBracket, 1'b0);
        add(KindInt, '0, line, col, '0, ErrNone, 1'b1);
        clear();
      end else begin
        scan(c);
      end
      if (pending_tokens.size() > n0) pending_tokens[pending_tokens.size()-1].last = 1'b1;
    endfunction

    function void compare(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        failed = 1;
      end
    endfunction

    function void check(logic [79:0] d, logic endr, logic last);
      token_t t;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, d);
        failed = 1;
        return;
      end
      t = pending_tokens.pop_front();
      compare("kind", t.kind, d[5:0]);
      compare("first_byte", t.first, d[13:6]);
      compare("line", t.line, d[33:14]);
      compare("column", t.col, d[49:34]);
      compare("length", t.len, d[65:50]);
      compare("level", t.level, d[72:66]);
      compare("error", t.err, d[75:73]);
      compare("fill", 0, d[79:76]);
      compare("end_report", t.endr, endr);
      compare("last", t.last, last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  token_board sb = new();
  int send_idle = 37;
  int recv_idle = 49;
  int bytes_sent = 0;

  source_token_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= $urandom_range(99) >= recv_idle;
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // guard: swap a byte that would stop the scanner for a space
  task automatic put_byte(logic [7:0] c, bit eot = 0, bit guard = 1);
    token_board trial;
    if (guard && !eot) begin
      trial = new sb;
      trial.note(c, 1'b0);
      if (trial.halted) c = " ";
    end
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= eot ? 8'($urandom_range(255)) : c;
    s_axis_tuser  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(c, eot);
    bytes_sent++;
  endtask

  task automatic send_fragment();
    int sel, n;
    logic [7:0] qt, top;
    string digs = "0123456789";
    string alph = "abqxyzAQZ_$";
    string ops = "+-*/=!><.:";
    string seconds = "+-=><.:";
    string body = "*a/\n";
    string ws = " \t\r\n";
    string opens = "([{";
    sel = $urandom_range(12);
    n = $urandom_range(1, 4);
    case (sel)
      0: repeat (n) put_byte(digs[$urandom_range(9)]);
      1: begin
        repeat (n) put_byte(digs[$urandom_range(9)]);
        put_byte(".");
        repeat ($urandom_range(2)) put_byte(digs[$urandom_range(9)]);
      end
      2: begin
        put_byte(alph[$urandom_range(alph.len()-1)]);
        repeat (n) put_byte($urandom_range(1) ? alph[$urandom_range(alph.len()-1)] :
                                                  digs[$urandom_range(9)]);
      end
      3, 4: begin
        qt = sel == 3 ? "\"" : "'";
        put_byte(qt);
        repeat ($urandom_range(4)) put_byte($urandom_range(1) ? 8'($urandom_range(255)) : "\n");
        if ($urandom_range(3) != 0) put_byte(qt);
      end
      5: begin
        put_byte(ops[$urandom_range(ops.len()-1)]);
        if ($urandom_range(1)) put_byte(seconds[$urandom_range(seconds.len()-1)]);
      end
      6: put_byte(opens[$urandom_range(2)]);
      7: begin
        top = sb.depth > 0 ? sb.opens[sb.depth-1] : "(";
        put_byte(top == "(" ? ")" : top == "[" ? "]" : "}");
      end
      8: begin
        put_byte("#");
        repeat (n) put_byte(8'($urandom_range(32, 126)));
        put_byte("\n");
      end
      9: begin
        put_byte("/");
        put_byte("/");
        repeat (n) put_byte(8'($urandom_range(32, 126)));
        put_byte("\n");
      end
      10: begin
        put_byte("/");
        put_byte("*");
        repeat (n) put_byte(body[$urandom_range(3)]);
        put_byte("*");
        put_byte("/");
      end
      11: put_byte(8'($urandom_range(255)));
      default: put_byte(ws[$urandom_range(3)]);
    endcase
    if ($urandom_range(3) != 0) put_byte(ws[$urandom_range(3)]);
  endtask

  initial begin
    string lead = "( 9. $a1 /*/ x";
    int base;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (lead[i]) put_byte(lead[i]);
    put_byte(8'h00, 1);
    put_byte("'");
    put_byte("q");
    put_byte(8'h00, 1);
    put_byte("/");
    put_byte("*");
    put_byte("z");
    put_byte(8'h00, 1);
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'h00, 1);

    base = bytes_sent;
    while (bytes_sent - base < 250) begin
      if (bytes_sent - base < 85) begin
        send_idle = 37;
        recv_idle = 49;
      end else if (bytes_sent - base < 170) begin
        send_idle = 49;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat ($urandom_range(2, 10)) send_fragment();
      put_byte(8'h00, 1);
    end

    // stop the scanner on purpose, then feed bytes it must ignore
    case ($urandom_range(2))
      0: begin
        put_byte("1", 0, 0);
        put_byte(".", 0, 0);
        put_byte(".", 0, 0);
      end
      1: put_byte("]", 0, 0);
      default: repeat (BracketDepth + 1) put_byte("{", 0, 0);
    endcase
    put_byte("7", 0, 0);
    put_byte(8'h00, 1, 0);
    s_axis_tvalid <= 1'b0;

    while (sb.pending_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (!sb.failed) $display("[source_token_scanner_core] OK");
    else $display("[source_token_scanner_core] ERROR");
    $finish;
  end

  initial begin
    #1000000;
    $display("[source_token_scanner_core] ERROR");
    $finish;
  end

endmodule

/* source_token_scanner_core.f */
sv/sts_pkg.sv
sv/sts_out_queue.sv
sv/sts_scan.sv
sv/source_token_scanner_core.sv
tb/source_token_scanner_core_tb.sv
